// ===== design/lgu_pkg.sv =====
// ----------------------------------------------------------------------------
// lgu_pkg
// Shared types, constants and helpers of the loss and gradient unit.
// ----------------------------------------------------------------------------
package lgu_pkg;

    localparam logic [1:0] KIND_NULL  = 2'd0;
    localparam logic [1:0] KIND_MSE   = 2'd1;
    localparam logic [1:0] KIND_CCE   = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [2:0] ADDR_KIND = 3'd0;
    localparam logic [2:0] ADDR_GRAD = 3'd4;

    localparam logic signed [31:0] Q_LN2   = 32'sd11629080;
    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_INTERP,
        ST_LNSUM,
        ST_TERM,
        ST_MSQ,
        ST_ACCUM,
        ST_FINAL,
        ST_DIVW,
        ST_EMIT
    } t_state;

    // ln(1 + i/16) in Q.24
    function automatic logic [23:0] ln_tab(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd0;
            5'd1:    v = 24'd1017112;
            5'd2:    v = 24'd1976072;
            5'd3:    v = 24'd2883169;
            5'd4:    v = 24'd3743728;
            5'd5:    v = 24'd4562291;
            5'd6:    v = 24'd5342767;
            5'd7:    v = 24'd6088544;
            5'd8:    v = 24'd6802576;
            5'd9:    v = 24'd7487455;
            5'd10:   v = 24'd8145470;
            5'd11:   v = 24'd8778647;
            5'd12:   v = 24'd9388795;
            5'd13:   v = 24'd9977530;
            5'd14:   v = 24'd10546303;
            5'd15:   v = 24'd11096425;
            5'd16:   v = 24'd11629080;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    // clip a 65-bit signed value to Q8.24; returns {clipped, value}
    function automatic logic [32:0] clip32(input logic signed [64:0] v);
        logic [32:0] r;
        if (v > 65'sd2147483647) begin
            r = {1'b1, I32_MAX};
        end else if (v < -65'sd2147483648) begin
            r = {1'b1, I32_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/loss_and_gradient_unit.sv =====
// ----------------------------------------------------------------------------
// loss_and_gradient_unit
// MSE / categorical cross entropy loss and gradient over Q8.24 streams.
// ----------------------------------------------------------------------------
// One item at a time; the input is not ready while an element is in work.
// Gradient mode: MSE, null and the cross entropy cases with a zero target or
// a zero divisor go straight to emit, the cross entropy divide through the
// 64-step divider plus setup and emit. Loss mode: null goes straight to the
// accumulate, MSE through the square, cross entropy through the term for a
// non-positive prediction and otherwise through the one-bit leading-one
// shifter (its run set by the magnitude of the prediction), interpolation
// and the log sum. The last element adds a final step, and for MSE the mean
// divide. A finished result sits in the output register while the next
// element is taken; a second result waits until that register drains, and
// the input stalls meanwhile.
// ----------------------------------------------------------------------------
module loss_and_gradient_unit #(
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] prediction, [63:32] target
    input  logic        i_s_tlast,   // last_element
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value
    output logic [1:0]  o_m_tuser    // [0] is_loss, [1] saturated
);

    localparam int CntW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_ELEMENTS);

    // configuration
    logic [1:0] r_kind;
    logic       r_grad;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= '0;
            r_grad <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr)
                lgu_pkg::ADDR_KIND: r_kind <= pwdata[1:0];
                lgu_pkg::ADDR_GRAD: r_grad <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            lgu_pkg::ADDR_KIND: prdata = {30'd0, r_kind};
            lgu_pkg::ADDR_GRAD: prdata = {31'd0, r_grad};
            default:            prdata = '0;
        endcase
    end

    // datapath state
    lgu_pkg::t_state r_state, n_state;
    logic signed [63:0] r_acc, n_acc;
    logic [CntW-1:0]    r_count, n_count;
    logic               r_sticky, n_sticky;
    logic signed [31:0] r_t, n_t;
    logic [32:0]        r_d, n_d;
    logic               r_last, n_last;
    logic               r_flag, n_flag;
    logic [30:0]        r_m, n_m;
    logic [4:0]         r_k, n_k;
    logic signed [31:0] r_ln, n_ln;
    logic               r_neg, n_neg;
    logic [31:0]        r_val, n_val;
    logic               r_isl, n_isl;
    logic               r_sat, n_sat;
    logic               r_ov, n_ov;
    logic [31:0]        r_odata, n_odata;
    logic [1:0]         r_ouser, n_ouser;

    // shared units
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic               div_start, div_busy, div_done;
    logic [63:0]        div_num, div_quot;
    logic [31:0]        div_den;

    lgu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    lgu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic signed [31:0] s_p, s_t;
    logic signed [32:0] s_q, s_dif;
    logic [32:0]        clip;
    logic [4:0]         idx;
    logic [23:0]        tab_lo, tab_hi;
    logic [20:0]        tab_dif;
    logic [26:0]        frac_r;
    logic signed [6:0]  kdiff;
    logic signed [31:0] kterm;
    logic signed [63:0] addend;
    logic signed [64:0] sum65;
    logic               aflag, cflag;

    assign s_p     = i_s_tdata[31:0];
    assign s_t     = i_s_tdata[63:32];
    assign s_q     = 33'(s_p) + 33'sd1;
    assign s_dif   = 33'(s_p) - 33'(s_t);
    assign idx     = {1'b0, r_m[29:26]};
    assign tab_lo  = lgu_pkg::ln_tab(idx);
    assign tab_hi  = lgu_pkg::ln_tab(idx + 5'd1);
    assign tab_dif = 21'(tab_hi - tab_lo);
    assign frac_r  = {r_m[25:0], 1'b0};
    assign kdiff   = $signed({2'b00, r_k}) - 7'sd24;
    assign kterm   = 32'(kdiff) * lgu_pkg::Q_LN2;

    always_comb begin
        unique case (r_state)
            lgu_pkg::ST_INTERP: begin
                mul_a = $signed({13'd0, tab_dif});
                mul_b = $signed({7'd0, frac_r});
            end
            lgu_pkg::ST_MSQ: begin
                mul_a = $signed({1'b0, r_d});
                mul_b = $signed({1'b0, r_d});
            end
            lgu_pkg::ST_TERM: begin
                mul_a = 34'(r_t);
                mul_b = 34'(r_ln);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_count  = r_count;
        n_sticky = r_sticky;
        n_t      = r_t;
        n_d      = r_d;
        n_last   = r_last;
        n_flag   = r_flag;
        n_m      = r_m;
        n_k      = r_k;
        n_ln     = r_ln;
        n_neg    = r_neg;
        n_val    = r_val;
        n_isl    = r_isl;
        n_sat    = r_sat;
        n_ov     = r_ov;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        clip      = '0;
        addend    = '0;
        sum65     = '0;
        aflag     = 1'b0;
        cflag     = 1'b0;
        o_s_tready = (r_state == lgu_pkg::ST_IDLE);

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            lgu_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_t    = s_t;
                    n_last = i_s_tlast;
                    n_flag = 1'b0;
                    n_d    = s_dif[32] ? 33'(-s_dif) : 33'(s_dif);
                    n_isl  = 1'b0;
                    n_sat  = 1'b0;
                    if (r_grad) begin
                        n_state = lgu_pkg::ST_EMIT;
                        case (r_kind)
                            lgu_pkg::KIND_MSE: begin
                                clip  = lgu_pkg::clip32(65'(s_dif));
                                n_val = clip[31:0];
                                n_sat = clip[32];
                            end
                            lgu_pkg::KIND_CCE: begin
                                if (s_t == 32'sd0) begin
                                    n_val = '0;
                                end else if (s_q == 33'sd0) begin
                                    n_sat = 1'b1;
                                    n_val = s_t[31] ? lgu_pkg::I32_MAX : lgu_pkg::I32_MIN;
                                end else begin
                                    // -t / (p + 1): magnitudes through the divider
                                    n_neg     = (s_t[31] == s_q[32]);
                                    div_start = 1'b1;
                                    div_num   = {8'd0, (s_t[31] ? 32'(-s_t) : 32'(s_t)),
                                                 24'd0};
                                    div_den   = s_q[32] ? 32'(-s_q) : 32'(s_q);
                                    n_state   = lgu_pkg::ST_DIVW;
                                end
                            end
                            default: n_val = s_p;
                        endcase
                    end else begin
                        case (r_kind)
                            lgu_pkg::KIND_MSE: n_state = lgu_pkg::ST_MSQ;
                            lgu_pkg::KIND_CCE: begin
                                if (s_p > 32'sd0) begin
                                    n_m     = s_p[30:0];
                                    n_k     = 5'd30;
                                    n_state = lgu_pkg::ST_NORM;
                                end else begin
                                    n_ln    = lgu_pkg::I32_MIN;
                                    n_flag  = 1'b1;
                                    n_state = lgu_pkg::ST_TERM;
                                end
                            end
                            default: n_state = lgu_pkg::ST_ACCUM;
                        endcase
                    end
                end
            end
            lgu_pkg::ST_NORM: begin
                // leading-one search, one bit a cycle
                if (r_m[30] || r_k == 5'd0) begin
                    n_state = lgu_pkg::ST_INTERP;
                end else begin
                    n_m = {r_m[29:0], 1'b0};
                    n_k = r_k - 5'd1;
                end
            end
            lgu_pkg::ST_INTERP: n_state = lgu_pkg::ST_LNSUM;
            lgu_pkg::ST_LNSUM: begin
                n_ln    = kterm + $signed({8'd0, tab_lo}) + $signed({11'd0, prod[47:27]});
                n_state = lgu_pkg::ST_TERM;
            end
            lgu_pkg::ST_TERM: n_state = lgu_pkg::ST_ACCUM;
            lgu_pkg::ST_MSQ:  n_state = lgu_pkg::ST_ACCUM;
            lgu_pkg::ST_ACCUM: begin
                case (r_kind)
                    lgu_pkg::KIND_MSE: addend = $signed({22'd0, prod[66:25]});
                    lgu_pkg::KIND_CCE: addend = -64'($signed(prod[67:24]));
                    default:           addend = '0;
                endcase
                sum65 = 65'(r_acc) + 65'(addend);
                if (sum65[64] != sum65[63]) begin
                    aflag = 1'b1;
                    n_acc = sum65[64] ? lgu_pkg::I64_MIN : lgu_pkg::I64_MAX;
                end else begin
                    n_acc = sum65[63:0];
                end
                if (r_count < CntMax) begin
                    n_count = r_count + CntW'(1);
                end else begin
                    cflag = 1'b1;
                end
                n_sticky = r_sticky | r_flag | aflag | cflag;
                n_state  = r_last ? lgu_pkg::ST_FINAL : lgu_pkg::ST_IDLE;
            end
            lgu_pkg::ST_FINAL: begin
                n_isl    = 1'b1;
                n_sat    = r_sticky;
                n_state  = lgu_pkg::ST_EMIT;
                case (r_kind)
                    lgu_pkg::KIND_MSE: begin
                        div_start = 1'b1;
                        div_num   = r_acc[63] ? 64'd0 : r_acc;
                        div_den   = (r_count == '0) ? 32'd1 : 32'(r_count);
                        n_state   = lgu_pkg::ST_DIVW;
                    end
                    lgu_pkg::KIND_CCE: begin
                        clip  = lgu_pkg::clip32(65'(r_acc));
                        n_val = clip[31:0];
                        n_sat = r_sticky | clip[32];
                    end
                    default: n_val = '0;
                endcase
                n_acc    = '0;
                n_count  = '0;
                n_sticky = 1'b0;
            end
            lgu_pkg::ST_DIVW: begin
                if (div_done) begin
                    n_state = lgu_pkg::ST_EMIT;
                    if (r_isl) begin
                        if (div_quot > 64'h7FFF_FFFF) begin
                            n_val = lgu_pkg::I32_MAX;
                            n_sat = 1'b1;
                        end else begin
                            n_val = div_quot[31:0];
                        end
                    end else if (r_neg) begin
                        if (div_quot > 64'h8000_0000) begin
                            n_val = lgu_pkg::I32_MIN;
                            n_sat = 1'b1;
                        end else begin
                            n_val = 32'(-div_quot[31:0]);
                        end
                    end else if (div_quot > 64'h7FFF_FFFF) begin
                        n_val = lgu_pkg::I32_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_val = div_quot[31:0];
                    end
                end
            end
            lgu_pkg::ST_EMIT: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_odata = r_val;
                    n_ouser = {r_sat, r_isl};
                    n_state = lgu_pkg::ST_IDLE;
                end
            end
            default: n_state = lgu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lgu_pkg::ST_IDLE;
            r_acc    <= '0;
            r_count  <= '0;
            r_sticky <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_count  <= n_count;
            r_sticky <= n_sticky;
            r_ov     <= n_ov;
        end
        r_t     <= n_t;
        r_d     <= n_d;
        r_last  <= n_last;
        r_flag  <= n_flag;
        r_m     <= n_m;
        r_k     <= n_k;
        r_ln    <= n_ln;
        r_neg   <= n_neg;
        r_val   <= n_val;
        r_isl   <= n_isl;
        r_sat   <= n_sat;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !o_s_tready) else $error("input taken during divide");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgu_pkg::ST_FINAL) |=> (r_acc == '0 && r_count == '0 && !r_sticky))
        else $error("loss state not cleared after last element");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax) else $error("element count beyond limit");
    a_divw_has_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgu_pkg::ST_DIVW && !div_done) |-> div_busy)
        else $error("waiting on idle divider");
`endif

endmodule

// ===== design/lgu_mul.sv =====
// ----------------------------------------------------------------------------
// lgu_mul
// Shared signed 34x34 multiplier with registered product.
// ----------------------------------------------------------------------------
module lgu_mul (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [67:0] o_p
);

    logic signed [67:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 68'(i_a) * 68'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== design/lgu_div.sv =====
// ----------------------------------------------------------------------------
// lgu_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lgu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] rem_sh;
    logic [33:0] sub;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_sh = {r_rem[31:0], r_q[63]};
        sub    = {1'b0, rem_sh} - {2'b00, r_den};
        if (i_start && !r_busy) begin
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!sub[33]) begin
                n_rem = sub[32:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("divider done while busy");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> r_cnt != 7'd0) else $error("divider busy with zero count");
    a_start_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy && r_cnt == 7'd64)
        else $error("divider did not load");
`endif

endmodule
